>>> hdl/bpc_pkg.sv
package bpc_pkg;

  // field widths
  localparam int N_W       = 6;
  localparam int COUNT_W   = 63;
  localparam int PROD_W    = COUNT_W + N_W;
  localparam int REM_W     = N_W;
  localparam int DCNT_W    = $clog2(PROD_W);
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 64;

  localparam int DEFAULT_MAX_N = 63;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // operation codes
  localparam logic OP_NCR = 1'b0;
  localparam logic OP_NPR = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic perm_step;
    logic div_init;
    logic div_step;
    logic quo_take;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic zero;
    logic loop_done;
    logic op;
    logic ovf;
    logic div_last;
  } sts_t;

endpackage

>>> hdl/bpc_datapath.sv
module bpc_datapath #(
  parameter int MAX_N = bpc_pkg::DEFAULT_MAX_N
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bpc_pkg::cmd_t                    cmd,
  output bpc_pkg::sts_t                    sts,
  input  logic [bpc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,
  output logic [bpc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser
);

  localparam int N_W     = bpc_pkg::N_W;
  localparam int COUNT_W = bpc_pkg::COUNT_W;
  localparam int PROD_W  = bpc_pkg::PROD_W;
  localparam int REM_W   = bpc_pkg::REM_W;
  localparam int DCNT_W  = bpc_pkg::DCNT_W;
  localparam logic [N_W-1:0] MAX_N_V = N_W'(MAX_N);

  logic               op_r;
  logic               zero_r;
  logic               sat_r;
  logic [N_W-1:0]     n_r;
  logic [N_W-1:0]     k_r;
  logic [N_W-1:0]     i_r;
  logic [COUNT_W-1:0] acc_r;
  logic [PROD_W-1:0]  prod_r;
  logic [REM_W-1:0]   rem_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_sat_r;

  logic [N_W-1:0]     n_in;
  logic [N_W-1:0]     n_clamp;
  logic [N_W-1:0]     r_in;
  logic [N_W-1:0]     n_minus_r;
  logic [N_W-1:0]     k_in;
  logic [N_W-1:0]     factor;
  logic [N_W-1:0]     den;
  logic [REM_W:0]     trial;
  logic [REM_W:0]     trial_sub;
  logic               trial_ge;
  logic               ovf;

  // input decode: clamp n, pick the shorter side for combinations
  assign n_in      = in_tdata[N_W-1:0];
  assign r_in      = in_tdata[2*N_W-1:N_W];
  assign n_clamp   = (n_in > MAX_N_V) ? MAX_N_V : n_in;
  assign n_minus_r = n_clamp - r_in;
  assign k_in      = ((in_tuser == bpc_pkg::OP_NCR) && (n_minus_r < r_in)) ? n_minus_r : r_in;

  // step operands
  assign factor    = n_r - i_r;
  assign den       = i_r + N_W'(1);
  assign ovf       = |prod_r[PROD_W-1:COUNT_W];

  // one restoring divide step
  assign trial     = {rem_r, prod_r[PROD_W-1]};
  assign trial_ge  = (trial >= {1'b0, den});
  assign trial_sub = trial - {1'b0, den};

  // operand and loop registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_tuser;
      n_r    <= n_clamp;
      k_r    <= k_in;
      zero_r <= (r_in > n_clamp);
      i_r    <= '0;
      acc_r  <= COUNT_W'(1);
      sat_r  <= 1'b0;
    end
    if (cmd.mul) begin
      prod_r <= {{N_W{1'b0}}, acc_r} * {{COUNT_W{1'b0}}, factor};
    end
    if (cmd.perm_step) begin
      if (ovf) begin
        acc_r <= bpc_pkg::COUNT_MAX;
        sat_r <= 1'b1;
      end else begin
        acc_r <= prod_r[COUNT_W-1:0];
        i_r   <= i_r + N_W'(1);
      end
    end
    if (cmd.div_init) begin
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      prod_r <= {prod_r[PROD_W-2:0], trial_ge};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.quo_take) begin
      acc_r <= prod_r[COUNT_W-1:0];
      i_r   <= i_r + N_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r <= zero_r ? '0 : acc_r;
      out_sat_r   <= sat_r & ~zero_r;
    end
  end

  assign sts.zero      = zero_r;
  assign sts.loop_done = (i_r == k_r);
  assign sts.op        = op_r;
  assign sts.ovf       = ovf;
  assign sts.div_last  = (dcnt_r == DCNT_W'(PROD_W - 1));

  assign out_tdata = {{(bpc_pkg::OUT_DATA_W - COUNT_W){1'b0}}, out_count_r};
  assign out_tuser = out_sat_r;

  // the overflow branch clamps the count and sets the saturation flag
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.perm_step && ovf |=> acc_r == bpc_pkg::COUNT_MAX && sat_r)
    else $error("saturation did not clamp the count");

  // exact division leaves a quotient that fits the count width
  a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.quo_take |-> !ovf)
    else $error("quotient wider than count");

endmodule

>>> hdl/bpc_controller.sv
module bpc_controller (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output bpc_pkg::cmd_t cmd,
  input  bpc_pkg::sts_t sts
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_ACC    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_QUO    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  // sequencing of one item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.zero || sts.loop_done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (sts.op == bpc_pkg::OP_NPR) begin
          cmd.perm_step = 1'b1;
          state_nxt     = sts.ovf ? ST_FINISH : ST_CHECK;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_QUO;
        end
      end
      ST_QUO: begin
        cmd.quo_take = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // an accepted item starts with the loop check
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ST_CHECK)
    else $error("accepted item did not start");

  // the divider runs its full count
  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !sts.div_last) |=> state_r == ST_DIV)
    else $error("divide ended early");

endmodule

>>> hdl/binomial_and_permutation_count.sv
// Binomial and permutation counter.
// Input channel (in_*): one transfer gives n and r in in_tdata and the
// operation in in_tuser (0 = nCr, 1 = nPr). Result channel (out_*): one
// transfer per input item, the count in out_tdata and the saturation flag
// in out_tuser. n above MAX_N is clamped; r above n gives a count of 0.
// nCr runs k = min(r, n-r) steps, each a 63x6 multiply and a 69-bit
// restoring divide at one quotient bit per cycle. nPr runs r multiply
// steps, stopping early when the product saturates. The block holds one
// item at a time; in_tready is high only while it is waiting for an item,
// and a new item is taken while the previous result still sits in the
// output register. If the receiver stalls, the result waits in the output
// register and the next item finishes its work, then holds until that
// register is taken. Reset (rst_n low, synchronous) empties the output
// register and returns the sequencer to waiting for an item.
module binomial_and_permutation_count #(
  parameter int MAX_N = bpc_pkg::DEFAULT_MAX_N
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata: n_total [5:0], r_chosen [11:6], zero fill [15:12]
  input  logic [bpc_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: operation [0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: count [62:0], zero fill [63]
  output logic [bpc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: saturated [0]
  output logic                             out_tuser
);

  bpc_pkg::cmd_t cmd;
  bpc_pkg::sts_t sts;

  bpc_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  bpc_datapath #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
